// ===== design/deque_with_delete_by_match_defines.svh =====
// Assertion helpers for the deque block.
`ifndef DEQUE_WITH_DELETE_BY_MATCH_DEFINES_SVH
`define DEQUE_WITH_DELETE_BY_MATCH_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DQDM_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DQDM_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

// ===== design/dqdm_pkg.sv =====
package dqdm_pkg;

  localparam int unsigned ITEM_PORT_W = 32;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_PUT_FRONT = 2'd0;
  localparam cmd_t CMD_PUT_BACK  = 2'd1;
  localparam cmd_t CMD_TAKE      = 2'd2;
  localparam cmd_t CMD_DELETE    = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_ILLEGAL   = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

// ===== design/dqdm_ram.sv =====
module dqdm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== design/deque_with_delete_by_match.sv =====
// Bounded double-ended queue of nonzero handles held in a circular buffer in one
// 1R1W RAM, with head, tail and fill registers. One command is handled at a time.
// A legal put writes one RAM entry; a take reads the head entry and returns it.
// A delete searches from front to back (one RAM read and one compare per entry
// visited), then moves each entry behind the match up one place (one read and
// one write each) and drops the tail entry. A further command is accepted once
// the sequencer is idle; a result may still be waiting on the output then. No
// clearing pass is needed.
module deque_with_delete_by_match #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dqdm_pkg::cmd_t                     in_cmd,
  input  logic [dqdm_pkg::ITEM_PORT_W-1:0]   in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dqdm_pkg::status_t                  out_status,
  output logic [dqdm_pkg::ITEM_PORT_W-1:0]   out_item,
  output logic [$clog2(CAPACITY+1)-1:0]      out_count
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SW    = (ITEM_WIDTH < dqdm_pkg::ITEM_PORT_W) ?
                                  ITEM_WIDTH : dqdm_pkg::ITEM_PORT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_TK_D   = 3'd2;
  localparam logic [2:0] S_SR_RD  = 3'd3;
  localparam logic [2:0] S_SR_CMP = 3'd4;
  localparam logic [2:0] S_SH_RD  = 3'd5;
  localparam logic [2:0] S_SH_WR  = 3'd6;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(CAPACITY - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(CAPACITY - 1) : AW'(p - 1'b1);
  endfunction

  logic [2:0]              state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [AW-1:0]           tail_r, tail_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  dqdm_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [SW-1:0]           key_r, key_nxt;

  logic                    out_valid_r, out_valid_nxt;
  dqdm_pkg::status_t       status_r, status_nxt;
  logic [SW-1:0]           oitem_r, oitem_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [SW-1:0]           wr_data, rd_data;
  logic                    out_free, in_acc, last_idx;
  logic                    ptr_ok;

  dqdm_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign last_idx   = (CNT_W'(idx_r + 1'b1) == fill_r);
  assign ptr_ok     = (int'(head_r) + int'(fill_r) == int'(tail_r)) ||
                      (int'(head_r) + int'(fill_r) == int'(tail_r) + int'(CAPACITY));

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_item   = dqdm_pkg::ITEM_PORT_W'(oitem_r);
  assign out_count  = count_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    oitem_nxt     = oitem_r;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = key_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_cmd;
          key_nxt   = in_item[SW-1:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == dqdm_pkg::CMD_PUT_FRONT || cmd_r == dqdm_pkg::CMD_PUT_BACK) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            oitem_nxt     = '0;
            count_nxt     = fill_r;
            state_nxt     = S_IDLE;
            if (key_r == '0) begin
              status_nxt = dqdm_pkg::ST_ILLEGAL;
            end else if (fill_r == CNT_W'(CAPACITY)) begin
              status_nxt = dqdm_pkg::ST_FULL;
            end else begin
              status_nxt = dqdm_pkg::ST_OK;
              wr_en      = 1'b1;
              fill_nxt   = CNT_W'(fill_r + 1'b1);
              count_nxt  = CNT_W'(fill_r + 1'b1);
              if (cmd_r == dqdm_pkg::CMD_PUT_FRONT) begin
                wr_addr  = ptr_dec(head_r);
                head_nxt = ptr_dec(head_r);
              end else begin
                wr_addr  = tail_r;
                tail_nxt = ptr_inc(tail_r);
              end
            end
          end
        end else if (cmd_r == dqdm_pkg::CMD_TAKE && fill_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = S_TK_D;
        end else if (cmd_r == dqdm_pkg::CMD_DELETE && key_r != '0 && fill_r != '0) begin
          idx_nxt   = '0;
          ptr_nxt   = head_r;
          state_nxt = S_SR_RD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = dqdm_pkg::ST_ILLEGAL;
          oitem_nxt     = '0;
          count_nxt     = fill_r;
          state_nxt     = S_IDLE;
        end
      end
      S_TK_D: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = dqdm_pkg::ST_OK;
          oitem_nxt     = rd_data;
          head_nxt      = ptr_inc(head_r);
          fill_nxt      = CNT_W'(fill_r - 1'b1);
          count_nxt     = CNT_W'(fill_r - 1'b1);
          state_nxt     = S_IDLE;
        end
      end
      S_SR_RD: begin
        rd_en     = 1'b1;
        rd_addr   = ptr_r;
        state_nxt = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (rd_data == key_r) begin
          state_nxt = S_SH_RD;
        end else if (last_idx) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = dqdm_pkg::ST_NOT_FOUND;
            oitem_nxt     = '0;
            count_nxt     = fill_r;
            state_nxt     = S_IDLE;
          end
        end else begin
          idx_nxt   = CNT_W'(idx_r + 1'b1);
          ptr_nxt   = ptr_inc(ptr_r);
          state_nxt = S_SR_RD;
        end
      end
      S_SH_RD: begin
        if (last_idx) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = dqdm_pkg::ST_OK;
            oitem_nxt     = '0;
            tail_nxt      = ptr_dec(tail_r);
            fill_nxt      = CNT_W'(fill_r - 1'b1);
            count_nxt     = CNT_W'(fill_r - 1'b1);
            state_nxt     = S_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_inc(ptr_r);
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = ptr_r;
        wr_data   = rd_data;
        ptr_nxt   = ptr_inc(ptr_r);
        idx_nxt   = CNT_W'(idx_r + 1'b1);
        state_nxt = S_SH_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    ptr_r    <= ptr_nxt;
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    oitem_r  <= oitem_nxt;
    count_r  <= count_nxt;
  end

`include "deque_with_delete_by_match_defines.svh"

  `DQDM_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CNT_W'(CAPACITY), "fill above capacity")
  `DQDM_ASSERT_IMP(a_ptr_consistent, 1'b1, ptr_ok, "head, tail and fill disagree")
  `DQDM_ASSERT_NXT(a_busy_after_accept, in_acc, state_r == S_EXEC, "accepted beat not executed")

endmodule
